FILE: src/outstanding_transaction_tracker_assert.svh
// Assertion macros for the outstanding transaction tracker.
`ifndef OUTSTANDING_TRANSACTION_TRACKER_ASSERT_SVH
`define OUTSTANDING_TRANSACTION_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define OTT_ASSERT_IMPL(label, clk_s, rst_s, prop, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define OTT_ASSERT_HOLD(label, clk_s, rst_s, vld, rdy, sig, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) \
        (vld && !rdy) |=> (vld && $stable(sig))) else $error(msg);
`else
`define OTT_ASSERT_IMPL(label, clk_s, rst_s, prop, msg)
`define OTT_ASSERT_HOLD(label, clk_s, rst_s, vld, rdy, sig, msg)
`endif
`endif

FILE: src/ott_pkg.sv
// Shared constants and types of the outstanding transaction tracker.
package ott_pkg;
    localparam int TableDepth = 16;
    localparam logic [31:0] LifetimeReset = 32'd1000000;
    localparam logic [15:0] NextIdReset = 16'd1;

    localparam logic [1:0] ACT_CREATE = 2'd0;
    localparam logic [1:0] ACT_ACCEPT = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [2:0] KIND_CREATED    = 3'd0;
    localparam logic [2:0] KIND_ACCEPTED   = 3'd1;
    localparam logic [2:0] KIND_ACCEPT_MISS = 3'd2;
    localparam logic [2:0] KIND_REMOVED    = 3'd3;
    localparam logic [2:0] KIND_REMOVE_MISS = 3'd4;
    localparam logic [2:0] KIND_TIMED_OUT  = 3'd5;
    localparam logic [2:0] KIND_FULL       = 3'd6;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] result_id;
        logic [15:0] result_peer;
        logic [31:0] rtt_us;
        logic [31:0] accept_time_us;
        logic        accept_seen;
        logic        last;
    } result_t;
endpackage

FILE: src/ott_core.sv
// Table, sequencer and shared compare unit of the tracker.
module ott_core #(
    parameter int TABLE_DEPTH = ott_pkg::TableDepth
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [31:0]        lifetime_us,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic [15:0]        txn_id,
    input  logic [15:0]        peer,
    input  logic [31:0]        now_us,
    output logic               res_valid,
    input  logic               res_ready,
    output ott_pkg::result_t   res
);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_READ = 5'b00100,
        ST_EMIT = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [15:0] id_mem [TABLE_DEPTH];
    logic [15:0] peer_mem [TABLE_DEPTH];
    logic [31:0] offer_mem [TABLE_DEPTH];
    logic [31:0] acc_mem [TABLE_DEPTH];
    logic        acc_seen_mem [TABLE_DEPTH];
    logic [IW-1:0] rank_mem [TABLE_DEPTH];

    logic [15:0] next_id_reg;
    logic [1:0]  act_reg;
    logic [15:0] txn_reg, peer_reg;
    logic [31:0] now_reg;
    logic [CW-1:0] rank_reg;     // rank being probed
    logic [IW-1:0] slot_reg;     // slot under test
    logic        found_reg;
    logic        out_valid_reg;
    ott_pkg::result_t out_reg;

    // Count and rank search: one slot per cycle is too slow for rank lookup, so
    // the rank-to-slot match is a parallel compare over valid bits (narrow).
    logic [CW-1:0] count;
    logic          hit;
    logic [IW-1:0] hit_slot;
    logic [IW-1:0] free_slot;
    logic          any_free;

    always_comb
    begin
        count = '0;
        hit = 1'b0;
        hit_slot = '0;
        free_slot = '0;
        any_free = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (valid_reg[i])
                count = count + 1'b1;
            if (valid_reg[i] && {1'b0, rank_mem[i]} == {1'b0, rank_reg[IW-1:0]}
                && !hit && rank_reg < CW'(TABLE_DEPTH))
            begin
                hit = 1'b1;
                hit_slot = IW'(i);
            end
            if (!valid_reg[i] && !any_free)
            begin
                any_free = 1'b1;
                free_slot = IW'(i);
            end
        end
    end

    // Shared unit: age or ID compare on the selected slot
    logic [31:0] age;
    logic        expired, id_match;
    assign age = now_reg - offer_mem[slot_reg];
    assign expired = age > lifetime_us;
    assign id_match = id_mem[slot_reg] == txn_reg;

    logic [15:0] id_inc;
    assign id_inc = (next_id_reg + 16'd1 == 16'd0) ? 16'd1 : next_id_reg + 16'd1;

    assign in_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign res_valid = out_valid_reg;
    assign res = out_reg;

    logic emit_free;
    assign emit_free = !out_valid_reg || res_ready;

    // a new result enters the output register
    logic out_load;
    assign out_load = emit_free && (state_reg == ST_DONE
        || (state_reg == ST_EMIT && act_reg == ott_pkg::ACT_CREATE && expired));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid && in_ready)
                    state_next = (action == ott_pkg::ACT_UNUSED) ? ST_IDLE : ST_SCAN;
            ST_SCAN:
                if (rank_reg >= count)
                    state_next = ST_DONE;
                else
                    state_next = ST_READ;
            ST_READ:
                state_next = ST_EMIT;
            ST_EMIT:
                if (emit_free)
                    state_next = ST_SCAN;
            ST_DONE:
                if (emit_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            next_id_reg <= ott_pkg::NextIdReset;
            out_valid_reg <= 1'b0;
            rank_reg <= '0;
            slot_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (in_valid && in_ready)
                    begin
                        act_reg <= action;
                        txn_reg <= txn_id;
                        peer_reg <= peer;
                        now_reg <= now_us;
                        rank_reg <= '0;
                        found_reg <= 1'b0;
                    end
                ST_SCAN:
                    if (rank_reg < count)
                        slot_reg <= hit_slot;
                ST_READ:
                    ;
                ST_EMIT:
                    if (emit_free)
                    begin
                        if (act_reg == ott_pkg::ACT_CREATE && expired)
                        begin
                            out_reg <= '{ott_pkg::KIND_TIMED_OUT, id_mem[slot_reg],
                                         peer_mem[slot_reg], 32'd0, 32'd0, 1'b0, 1'b0};
                            valid_reg[slot_reg] <= 1'b0;
                            for (int i = 0; i < TABLE_DEPTH; i++)
                                if (valid_reg[i] && rank_mem[i] > rank_mem[slot_reg])
                                    rank_mem[i] <= rank_mem[i] - 1'b1;
                        end
                        else if (act_reg != ott_pkg::ACT_CREATE && id_match)
                        begin
                            found_reg <= 1'b1;
                            rank_reg <= CW'(TABLE_DEPTH);
                        end
                        else
                            rank_reg <= rank_reg + 1'b1;
                    end
                ST_DONE:
                    if (emit_free)
                    begin
                        if (act_reg == ott_pkg::ACT_CREATE)
                        begin
                            if (!any_free)
                                out_reg <= '{ott_pkg::KIND_FULL, 16'd0, peer_reg,
                                             32'd0, 32'd0, 1'b0, 1'b1};
                            else
                            begin
                                next_id_reg <= id_inc;
                                for (int i = 0; i < TABLE_DEPTH; i++)
                                    if (valid_reg[i])
                                        rank_mem[i] <= rank_mem[i] + 1'b1;
                                valid_reg[free_slot] <= 1'b1;
                                id_mem[free_slot] <= id_inc;
                                peer_mem[free_slot] <= peer_reg;
                                offer_mem[free_slot] <= now_reg;
                                acc_mem[free_slot] <= 32'd0;
                                acc_seen_mem[free_slot] <= 1'b0;
                                rank_mem[free_slot] <= '0;
                                out_reg <= '{ott_pkg::KIND_CREATED, id_inc, peer_reg,
                                             32'd0, 32'd0, 1'b0, 1'b1};
                            end
                        end
                        else if (act_reg == ott_pkg::ACT_ACCEPT)
                        begin
                            if (found_reg)
                            begin
                                acc_mem[slot_reg] <= now_reg;
                                acc_seen_mem[slot_reg] <= 1'b1;
                                out_reg <= '{ott_pkg::KIND_ACCEPTED, txn_reg, peer_reg,
                                             age, 32'd0, 1'b0, 1'b1};
                            end
                            else
                                out_reg <= '{ott_pkg::KIND_ACCEPT_MISS, txn_reg, peer_reg,
                                             32'd0, 32'd0, 1'b0, 1'b1};
                        end
                        else if (found_reg)
                        begin
                            out_reg <= '{ott_pkg::KIND_REMOVED, txn_reg,
                                         peer_mem[slot_reg], 32'd0,
                                         acc_seen_mem[slot_reg] ? acc_mem[slot_reg] : 32'd0,
                                         acc_seen_mem[slot_reg], 1'b1};
                            valid_reg[slot_reg] <= 1'b0;
                            for (int i = 0; i < TABLE_DEPTH; i++)
                                if (valid_reg[i] && rank_mem[i] > rank_mem[slot_reg])
                                    rank_mem[i] <= rank_mem[i] - 1'b1;
                        end
                        else
                            out_reg <= '{ott_pkg::KIND_REMOVE_MISS, txn_reg, 16'd0,
                                         32'd0, 32'd0, 1'b0, 1'b1};
                    end
                default:
                    ;
            endcase
        end
    end
endmodule

FILE: src/outstanding_transaction_tracker.sv
// Top level of the outstanding transaction tracker.
//  channel   | dir | fields (low bit first)
//  s_axis    | in  | tdata: action[1:0] txn_id[17:2] peer[33:18] now_us[65:34]
//  m_axis    | out | tdata: kind result_id result_peer rtt_us accept_time_us accept_seen
//            |     | tlast: last
//  cfg       | in  | cfg_we/cfg_wdata: lifetime_us
// Each table entry probed for an item passes through the scan, read and decide states,
// since a single compare unit serves the table; decide waits while a result is pending.
// Reset clears the valid bits and sets next ID and lifetime to their reset values at once; no clearing pass.
// The input stays not ready until the last result of an item has been taken.
module outstanding_transaction_tracker #(
    parameter int TABLE_DEPTH = ott_pkg::TableDepth
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,  // action, txn_id, peer, now_us, zero fill
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // kind[2:0] result_id[18:3] result_peer[34:19] rtt_us[66:35]
    // accept_time_us[98:67] accept_seen[99], zero fill to 104
    output logic [103:0] m_axis_tdata,
    output logic         m_axis_tlast
);
    logic [31:0] lifetime_reg;
    ott_pkg::result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lifetime_reg <= ott_pkg::LifetimeReset;
        else if (cfg_we)
            lifetime_reg <= cfg_wdata;
    end

    ott_core #(.TABLE_DEPTH(TABLE_DEPTH)) u_core (
        .clk(clk), .rst_n(rst_n), .lifetime_us(lifetime_reg),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .action(s_axis_tdata[1:0]), .txn_id(s_axis_tdata[17:2]),
        .peer(s_axis_tdata[33:18]), .now_us(s_axis_tdata[65:34]),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
    );

    assign m_axis_tdata = {4'd0, res.accept_seen, res.accept_time_us, res.rtt_us,
                           res.result_peer, res.result_id, res.kind};
    assign m_axis_tlast = res.last;

`include "outstanding_transaction_tracker_assert.svh"
    `OTT_ASSERT_IMPL(a_no_in_while_out, clk, rst_n, m_axis_tvalid |-> !s_axis_tready, "ready while result pending")
    `OTT_ASSERT_IMPL(a_kind_range, clk, rst_n, m_axis_tvalid |-> (m_axis_tdata[2:0] != 3'd7), "bad kind")
    `OTT_ASSERT_HOLD(a_out_hold, clk, rst_n, m_axis_tvalid, m_axis_tready, {m_axis_tlast, m_axis_tdata}, "result changed while stalled")
endmodule
